// ----- hw/rtl/vcag_pkg.sv -----
// vcag_pkg: shared types and codes for the velocity command authority gate
// holds event codes, authority codes, register indexes and word types
// no dependencies
`default_nettype none

package vcag_pkg;

   localparam logic [2:0] ACT_COMMAND       = 3'd0;
   localparam logic [2:0] ACT_TICK          = 3'd1;
   localparam logic [2:0] ACT_BEGIN_ACQUIRE = 3'd2;
   localparam logic [2:0] ACT_ACQUIRE_DONE  = 3'd3;
   localparam logic [2:0] ACT_BEGIN_RELEASE = 3'd4;
   localparam logic [2:0] ACT_RELEASE_DONE  = 3'd5;
   localparam logic [2:0] ACT_FORCE_RELEASE = 3'd6;
   localparam logic [2:0] ACT_DRIVE_RESULT  = 3'd7;

   localparam logic [1:0] MODE_RELEASED  = 2'd0;
   localparam logic [1:0] MODE_ACQUIRING = 2'd1;
   localparam logic [1:0] MODE_HELD      = 2'd2;
   localparam logic [1:0] MODE_RELEASING = 2'd3;

   localparam int          CSR_INDEX_WIDTH = 8;
   localparam logic [7:0]  REG_COMMAND_TIMEOUT = 8'd0;
   localparam logic [7:0]  REG_FAILURE_LIMIT   = 8'd1;

   localparam logic [31:0] COMMAND_TIMEOUT_RESET = 32'd500;
   localparam logic [7:0]  FAILURE_LIMIT_RESET   = 8'd3;

   localparam logic [15:0] IGNORED_MAX = 16'hffff;
   localparam logic [7:0]  STREAK_MAX  = 8'hff;

   typedef struct packed {
      logic [2:0]         action;
      logic signed [15:0] vel_x;
      logic signed [15:0] vel_y;
      logic signed [15:0] vel_yaw;
      logic [31:0]        now_time;
      logic               success;
      logic signed [31:0] fault_code;
   } req_item_type;

   typedef struct packed {
      logic               intent_valid;
      logic signed [15:0] out_vel_x;
      logic signed [15:0] out_vel_y;
      logic signed [15:0] out_vel_yaw;
      logic [1:0]         authority;
      logic [15:0]        ignored_commands;
      logic [7:0]         failure_streak;
      logic signed [31:0] last_error;
   } rsp_item_type;

   typedef struct packed {
      logic                       we;
      logic [CSR_INDEX_WIDTH-1:0] index;
      logic [31:0]                wdata;
   } csr_write_type;

endpackage

`default_nettype wire

// ----- hw/rtl/velocity_command_authority_gate_core.sv -----
// velocity command authority gate: top level with result register and csr port
// instantiates vcag_in_reg and vcag_update, depends on vcag_pkg
//
// usage:
//  - req_ channel carries one event word (action and its operands) per handshake;
//    every event gives exactly one rsp_ word with any velocity intent and status
//  - csr_ channel writes command_timeout (index 0) and failure_limit (index 1);
//    csr_ready is always high, writes are meant for when no event is in flight
//  - path: an accepted event goes through the input register and then the result
//    register, whose word is on rsp_ until it is taken
//  - throughput: one event per cycle while rsp_ready is high; the input and
//    result registers let a new word enter while the previous result waits
//  - stall: with rsp_ready low the result register holds, one more event
//    waits in the input register, then req_ready drops
//  - reset: synchronous, clears both stages, authority released, counters zero,
//    timeout 500 ticks, failure limit 3
`default_nettype none

module velocity_command_authority_gate_core (
   input  wire logic        clock,
   input  wire logic        reset,

   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [2:0]  req_action,
   input  wire logic signed [15:0] req_vel_x,
   input  wire logic signed [15:0] req_vel_y,
   input  wire logic signed [15:0] req_vel_yaw,
   input  wire logic [31:0] req_now_time,
   input  wire logic        req_success,
   input  wire logic signed [31:0] req_fault_code,

   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic             rsp_intent_valid,
   output logic signed [15:0] rsp_out_vel_x,
   output logic signed [15:0] rsp_out_vel_y,
   output logic signed [15:0] rsp_out_vel_yaw,
   output logic [1:0]       rsp_authority,
   output logic [15:0]      rsp_ignored_commands,
   output logic [7:0]       rsp_failure_streak,
   output logic signed [31:0] rsp_last_error,

   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic [vcag_pkg::CSR_INDEX_WIDTH-1:0] csr_index,
   input  wire logic [31:0] csr_wdata
);
   import vcag_pkg::*;

   req_item_type  req_item;
   req_item_type  item;
   rsp_item_type  result;
   rsp_item_type  rsp_ff;
   csr_write_type csr;
   logic          item_valid;
   logic          advance;
   logic          rsp_valid_ff, rsp_valid_in;

   assign req_item.action     = req_action;
   assign req_item.vel_x      = req_vel_x;
   assign req_item.vel_y      = req_vel_y;
   assign req_item.vel_yaw    = req_vel_yaw;
   assign req_item.now_time   = req_now_time;
   assign req_item.success    = req_success;
   assign req_item.fault_code = req_fault_code;

   assign csr_ready = 1'b1;
   assign csr.we    = csr_valid && csr_ready;
   assign csr.index = csr_index;
   assign csr.wdata = csr_wdata;

   assign advance      = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid_in = advance || (rsp_valid_ff && !rsp_ready);

   vcag_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .advance    (advance),
      .item_valid (item_valid),
      .item       (item)
   );

   vcag_update u_update (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .item    (item),
      .csr     (csr),
      .result  (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_intent_valid     = rsp_ff.intent_valid;
   assign rsp_out_vel_x        = rsp_ff.out_vel_x;
   assign rsp_out_vel_y        = rsp_ff.out_vel_y;
   assign rsp_out_vel_yaw      = rsp_ff.out_vel_yaw;
   assign rsp_authority        = rsp_ff.authority;
   assign rsp_ignored_commands = rsp_ff.ignored_commands;
   assign rsp_failure_streak   = rsp_ff.failure_streak;
   assign rsp_last_error       = rsp_ff.last_error;

endmodule

`default_nettype wire

// ----- hw/rtl/vcag_in_reg.sv -----
// vcag_in_reg: input register stage of the authority gate
// holds one accepted request word until the update stage takes it
// depends on vcag_pkg
`default_nettype none

module vcag_in_reg (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire vcag_pkg::req_item_type req_item,
   input  wire logic                  advance,
   output logic                       item_valid,
   output vcag_pkg::req_item_type     item
);
   import vcag_pkg::*;

   logic         valid_ff, valid_in;
   req_item_type item_ff;

   assign req_ready  = !valid_ff || advance;
   assign valid_in   = (req_valid && req_ready) || (valid_ff && !advance);
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/vcag_update.sv -----
// vcag_update: authority state, latched command, counters and config registers
// computes one result word per event and updates state when the event advances
// depends on vcag_pkg
`default_nettype none

module vcag_update (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire vcag_pkg::req_item_type  item,
   input  wire vcag_pkg::csr_write_type csr,
   output vcag_pkg::rsp_item_type       result
);
   import vcag_pkg::*;

   logic [31:0]        timeout_ff;
   logic [7:0]         limit_ff;
   logic [1:0]         mode_ff, mode_in;
   logic signed [15:0] vx_ff, vx_in;
   logic signed [15:0] vy_ff, vy_in;
   logic signed [15:0] vyaw_ff, vyaw_in;
   logic [31:0]        arrival_ff, arrival_in;
   logic               ever_ff, ever_in;
   logic               stop_ff, stop_in;
   logic [15:0]        ignored_ff, ignored_in;
   logic [7:0]         streak_ff, streak_in;
   logic signed [31:0] error_ff, error_in;

   logic [31:0] age;
   logic        stale;
   logic        cmd_zero;
   logic        in_zero;
   logic [7:0]  streak_bump;

   assign age         = item.now_time - arrival_ff;
   assign stale       = !ever_ff || (age > timeout_ff);
   assign cmd_zero    = (vx_ff == 16'sd0) && (vy_ff == 16'sd0) && (vyaw_ff == 16'sd0);
   assign in_zero     = (item.vel_x == 16'sd0) && (item.vel_y == 16'sd0)
                        && (item.vel_yaw == 16'sd0);
   assign streak_bump = (streak_ff < STREAK_MAX) ? streak_ff + 8'd1 : streak_ff;

   always_comb begin
      mode_in    = mode_ff;
      vx_in      = vx_ff;
      vy_in      = vy_ff;
      vyaw_in    = vyaw_ff;
      arrival_in = arrival_ff;
      ever_in    = ever_ff;
      stop_in    = stop_ff;
      ignored_in = ignored_ff;
      streak_in  = streak_ff;
      error_in   = error_ff;

      result              = '0;

      unique case (item.action) inside
         ACT_COMMAND: begin
            if (mode_ff != MODE_HELD && !in_zero && ignored_ff != IGNORED_MAX) begin
               ignored_in = ignored_ff + 16'd1;
            end
            vx_in      = item.vel_x;
            vy_in      = item.vel_y;
            vyaw_in    = item.vel_yaw;
            arrival_in = item.now_time;
            ever_in    = 1'b1;
         end
         ACT_TICK: begin
            if (mode_ff == MODE_HELD) begin
               if (stale || cmd_zero) begin
                  if (!stop_ff) begin
                     stop_in             = 1'b1;
                     result.intent_valid = 1'b1;
                  end
               end else begin
                  stop_in             = 1'b0;
                  result.intent_valid = 1'b1;
                  result.out_vel_x    = vx_ff;
                  result.out_vel_y    = vy_ff;
                  result.out_vel_yaw  = vyaw_ff;
               end
            end
         end
         ACT_BEGIN_ACQUIRE: begin
            mode_in   = MODE_ACQUIRING;
            streak_in = 8'd0;
         end
         ACT_ACQUIRE_DONE: begin
            mode_in = item.success ? MODE_HELD : MODE_RELEASED;
            stop_in = 1'b0;
         end
         ACT_BEGIN_RELEASE: begin
            mode_in = MODE_RELEASING;
         end
         ACT_RELEASE_DONE, ACT_FORCE_RELEASE: begin
            mode_in = MODE_RELEASED;
         end
         ACT_DRIVE_RESULT: begin
            error_in = item.fault_code;
            if (item.fault_code == 32'sd0) begin
               streak_in = 8'd0;
            end else begin
               streak_in = streak_bump;
               if (streak_bump >= limit_ff && mode_ff == MODE_HELD) begin
                  mode_in = MODE_RELEASED;
               end
            end
         end
         default: begin
         end
      endcase

      result.authority        = mode_in;
      result.ignored_commands = ignored_in;
      result.failure_streak   = streak_in;
      result.last_error       = error_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         timeout_ff <= COMMAND_TIMEOUT_RESET;
         limit_ff   <= FAILURE_LIMIT_RESET;
      end else if (csr.we) begin
         unique case (csr.index)
            REG_COMMAND_TIMEOUT: timeout_ff <= csr.wdata;
            REG_FAILURE_LIMIT:   limit_ff   <= csr.wdata[7:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= MODE_RELEASED;
         vx_ff      <= '0;
         vy_ff      <= '0;
         vyaw_ff    <= '0;
         arrival_ff <= '0;
         ever_ff    <= 1'b0;
         stop_ff    <= 1'b0;
         ignored_ff <= '0;
         streak_ff  <= '0;
         error_ff   <= '0;
      end else if (advance) begin
         mode_ff    <= mode_in;
         vx_ff      <= vx_in;
         vy_ff      <= vy_in;
         vyaw_ff    <= vyaw_in;
         arrival_ff <= arrival_in;
         ever_ff    <= ever_in;
         stop_ff    <= stop_in;
         ignored_ff <= ignored_in;
         streak_ff  <= streak_in;
         error_ff   <= error_in;
      end
   end

endmodule

`default_nettype wire

// ----- tb/sv/velocity_command_authority_gate_core_tb.sv -----
// velocity_command_authority_gate_core_tb: self-checking bench for the authority gate core
// drives event words with random gaps and csr writes, a scoreboard predicts every result word
// depends on vcag_pkg and velocity_command_authority_gate_core
`timescale 1ns / 100ps

module velocity_command_authority_gate_core_tb;
   import vcag_pkg::*;

   class gate_status_board;
      logic [31:0]  timeout;
      logic [7:0]   limit;
      logic [1:0]   mode;
      logic [15:0]  held_x, held_y, held_yaw;
      logic [31:0]  arrival;
      bit           ever_seen;
      bit           stop_sent;
      logic [15:0]  ignored;
      logic [7:0]   streak;
      logic [31:0]  last_err;
      rsp_item_type predicted_words[$];
      int           errors;

      function new();
         timeout   = COMMAND_TIMEOUT_RESET;
         limit     = FAILURE_LIMIT_RESET;
         mode      = MODE_RELEASED;
         held_x    = '0;
         held_y    = '0;
         held_yaw  = '0;
         arrival   = '0;
         ever_seen = 1'b0;
         stop_sent = 1'b0;
         ignored   = '0;
         streak    = '0;
         last_err  = '0;
         errors    = 0;
      endfunction

      function void set_register(logic [7:0] index, logic [31:0] data);
         if (index == REG_COMMAND_TIMEOUT) begin
            timeout = data;
         end else if (index == REG_FAILURE_LIMIT) begin
            limit = data[7:0];
         end
      endfunction

      function int pending();
         return predicted_words.size();
      endfunction

      function void accept_event(req_item_type ev);
         rsp_item_type r;
         logic [31:0]  age;
         bit           stale;
         bit           all_zero;
         r = '0;
         case (ev.action)
            ACT_COMMAND: begin
               if (mode != MODE_HELD && (ev.vel_x | ev.vel_y | ev.vel_yaw) != 16'd0
                   && ignored != IGNORED_MAX)
                  ignored++;
               held_x    = ev.vel_x;
               held_y    = ev.vel_y;
               held_yaw  = ev.vel_yaw;
               arrival   = ev.now_time;
               ever_seen = 1'b1;
            end
            ACT_TICK: begin
               if (mode == MODE_HELD) begin
                  age      = ev.now_time - arrival;
                  stale    = !ever_seen || (age > timeout);
                  all_zero = (held_x | held_y | held_yaw) == 16'd0;
                  if (stale || all_zero) begin
                     if (!stop_sent) begin
                        stop_sent      = 1'b1;
                        r.intent_valid = 1'b1;
                     end
                  end else begin
                     stop_sent      = 1'b0;
                     r.intent_valid = 1'b1;
                     r.out_vel_x    = held_x;
                     r.out_vel_y    = held_y;
                     r.out_vel_yaw  = held_yaw;
                  end
               end
            end
            ACT_BEGIN_ACQUIRE: begin
               mode   = MODE_ACQUIRING;
               streak = '0;
            end
            ACT_ACQUIRE_DONE: begin
               mode      = ev.success ? MODE_HELD : MODE_RELEASED;
               stop_sent = 1'b0;
            end
            ACT_BEGIN_RELEASE: mode = MODE_RELEASING;
            ACT_RELEASE_DONE, ACT_FORCE_RELEASE: mode = MODE_RELEASED;
            default: begin
               last_err = ev.fault_code;
               if (ev.fault_code == 32'sd0) begin
                  streak = '0;
               end else begin
                  if (streak != STREAK_MAX)
                     streak++;
                  if (streak >= limit && mode == MODE_HELD)
                     mode = MODE_RELEASED;
               end
            end
         endcase
         r.authority        = mode;
         r.ignored_commands = ignored;
         r.failure_streak   = streak;
         r.last_error       = last_err;
         predicted_words.push_back(r);
      endfunction

      function void flag(string field, logic [31:0] want, logic [31:0] got);
         if (want !== got) begin
            errors++;
            $display("%0t mismatch %s: expected %0h, actual %0h", $time, field, want, got);
         end
      endfunction

      function void check_word(rsp_item_type got);
         rsp_item_type want;
         if (predicted_words.size() == 0) begin
            errors++;
            $display("%0t unexpected result word, actual %0h", $time, got);
            return;
         end
         want = predicted_words.pop_front();
         flag("intent_valid", want.intent_valid, got.intent_valid);
         flag("out_vel_x", want.out_vel_x, got.out_vel_x);
         flag("out_vel_y", want.out_vel_y, got.out_vel_y);
         flag("out_vel_yaw", want.out_vel_yaw, got.out_vel_yaw);
         flag("authority", want.authority, got.authority);
         flag("ignored_commands", want.ignored_commands, got.ignored_commands);
         flag("failure_streak", want.failure_streak, got.failure_streak);
         flag("last_error", want.last_error, got.last_error);
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [2:0]          req_action = ACT_TICK;
   logic signed [15:0]  req_vel_x = '0;
   logic signed [15:0]  req_vel_y = '0;
   logic signed [15:0]  req_vel_yaw = '0;
   logic [31:0]         req_now_time = '0;
   logic                req_success = 1'b0;
   logic signed [31:0]  req_fault_code = '0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic                rsp_intent_valid;
   logic signed [15:0]  rsp_out_vel_x;
   logic signed [15:0]  rsp_out_vel_y;
   logic signed [15:0]  rsp_out_vel_yaw;
   logic [1:0]          rsp_authority;
   logic [15:0]         rsp_ignored_commands;
   logic [7:0]          rsp_failure_streak;
   logic signed [31:0]  rsp_last_error;
   logic                csr_valid = 1'b0;
   logic                csr_ready;
   logic [CSR_INDEX_WIDTH-1:0] csr_index = '0;
   logic [31:0]         csr_wdata = '0;

   gate_status_board board = new();
   bit          calm = 1'b0;
   int          words_sent = 0;
   logic [31:0] clock_now = '0;
   logic [31:0] last_cmd_time = '0;
   logic [31:0] cur_timeout = COMMAND_TIMEOUT_RESET;

   velocity_command_authority_gate_core dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_ready            (req_ready),
      .req_action           (req_action),
      .req_vel_x            (req_vel_x),
      .req_vel_y            (req_vel_y),
      .req_vel_yaw          (req_vel_yaw),
      .req_now_time         (req_now_time),
      .req_success          (req_success),
      .req_fault_code       (req_fault_code),
      .rsp_valid            (rsp_valid),
      .rsp_ready            (rsp_ready),
      .rsp_intent_valid     (rsp_intent_valid),
      .rsp_out_vel_x        (rsp_out_vel_x),
      .rsp_out_vel_y        (rsp_out_vel_y),
      .rsp_out_vel_yaw      (rsp_out_vel_yaw),
      .rsp_authority        (rsp_authority),
      .rsp_ignored_commands (rsp_ignored_commands),
      .rsp_failure_streak   (rsp_failure_streak),
      .rsp_last_error       (rsp_last_error),
      .csr_valid            (csr_valid),
      .csr_ready            (csr_ready),
      .csr_index            (csr_index),
      .csr_wdata            (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit take_gap();
      return !calm && ($urandom_range(99) < 36);
   endfunction

   always @(negedge clock) begin
      rsp_ready <= !take_gap();
   end

   // both handshakes sampled at the edge, result checked before the new word is noted
   always @(posedge clock) begin : watch
      rsp_item_type seen;
      req_item_type taken;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            seen.intent_valid     = rsp_intent_valid;
            seen.out_vel_x        = rsp_out_vel_x;
            seen.out_vel_y        = rsp_out_vel_y;
            seen.out_vel_yaw      = rsp_out_vel_yaw;
            seen.authority        = rsp_authority;
            seen.ignored_commands = rsp_ignored_commands;
            seen.failure_streak   = rsp_failure_streak;
            seen.last_error       = rsp_last_error;
            board.check_word(seen);
         end
         if (req_valid && req_ready) begin
            taken.action     = req_action;
            taken.vel_x      = req_vel_x;
            taken.vel_y      = req_vel_y;
            taken.vel_yaw    = req_vel_yaw;
            taken.now_time   = req_now_time;
            taken.success    = req_success;
            taken.fault_code = req_fault_code;
            board.accept_event(taken);
         end
      end
   end

   task automatic send_event(input req_item_type ev);
      @(negedge clock);
      if (take_gap()) begin
         req_valid <= 1'b0;
         do @(negedge clock); while (take_gap());
      end
      req_valid      <= 1'b1;
      req_action     <= ev.action;
      req_vel_x      <= ev.vel_x;
      req_vel_y      <= ev.vel_y;
      req_vel_yaw    <= ev.vel_yaw;
      req_now_time   <= ev.now_time;
      req_success    <= ev.success;
      req_fault_code <= ev.fault_code;
      do @(posedge clock); while (!req_ready);
      words_sent++;
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (board.pending() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input logic [7:0] index, input logic [31:0] data);
      drain();
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= index;
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      board.set_register(index, data);
      if (index == REG_COMMAND_TIMEOUT)
         cur_timeout = data;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic req_item_type random_word();
      req_item_type ev;
      ev.action     = 3'($urandom_range(7));
      ev.vel_x      = 16'($urandom);
      ev.vel_y      = 16'($urandom);
      ev.vel_yaw    = 16'($urandom);
      ev.now_time   = $urandom;
      ev.success    = 1'($urandom_range(1));
      ev.fault_code = $urandom;
      return ev;
   endfunction

   function automatic req_item_type event_of(logic [2:0] action, logic [15:0] vx,
                                             logic [15:0] vy, logic [15:0] vyaw,
                                             logic [31:0] now, logic ok, logic [31:0] code);
      req_item_type ev;
      ev.action     = action;
      ev.vel_x      = vx;
      ev.vel_y      = vy;
      ev.vel_yaw    = vyaw;
      ev.now_time   = now;
      ev.success    = ok;
      ev.fault_code = code;
      return ev;
   endfunction

   function automatic logic [15:0] pick_speed();
      case ($urandom_range(9))
         0, 1: return 16'h0000;
         2: return 16'h7fff;
         3: return 16'h8000;
         4: return 16'hffff;
         default: return 16'($urandom);
      endcase
   endfunction

   function automatic logic [31:0] pick_code();
      case ($urandom_range(9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3, 4: return $urandom;
         default: return 32'h0;
      endcase
   endfunction

   task automatic send_command();
      req_item_type ev;
      ev = random_word();
      ev.action = ACT_COMMAND;
      if ($urandom_range(4) == 0) begin
         ev.vel_x   = 16'h0;
         ev.vel_y   = 16'h0;
         ev.vel_yaw = 16'h0;
      end else begin
         ev.vel_x   = pick_speed();
         ev.vel_y   = pick_speed();
         ev.vel_yaw = pick_speed();
      end
      if ($urandom_range(9) != 0)
         clock_now = clock_now + $urandom_range(0, 40);
      else
         clock_now = $urandom;
      ev.now_time   = clock_now;
      last_cmd_time = clock_now;
      send_event(ev);
   endtask

   task automatic send_tick();
      req_item_type ev;
      ev = random_word();
      ev.action = ACT_TICK;
      case ($urandom_range(9))
         0: ev.now_time = last_cmd_time + cur_timeout;
         1: ev.now_time = last_cmd_time + cur_timeout + 32'd1;
         2: ev.now_time = $urandom;
         default: begin
            clock_now   = clock_now + $urandom_range(0, 40);
            ev.now_time = clock_now;
         end
      endcase
      send_event(ev);
   endtask

   task automatic send_drive_result();
      req_item_type ev;
      ev = random_word();
      ev.action     = ACT_DRIVE_RESULT;
      ev.fault_code = pick_code();
      send_event(ev);
   endtask

   task automatic send_drive_result_error();
      req_item_type ev;
      ev = random_word();
      ev.action = ACT_DRIVE_RESULT;
      if (ev.fault_code == 32'sd0)
         ev.fault_code = 32'sd5;
      send_event(ev);
   endtask

   // sessions of acquire, traffic and an optional release with some noise words in between
   task automatic run_batch(input int count);
      int          stop_at;
      int          body;
      req_item_type ev;
      stop_at = words_sent + count;
      clock_now = ($urandom_range(3) == 0) ? 32'hffff_ff00 : $urandom;
      while (words_sent < stop_at) begin
         if ($urandom_range(99) < 15) begin
            send_event(random_word());
         end else begin
            ev = random_word();
            ev.action = ACT_BEGIN_ACQUIRE;
            send_event(ev);
            ev = random_word();
            ev.action  = ACT_ACQUIRE_DONE;
            ev.success = ($urandom_range(99) < 85);
            send_event(ev);
            body = $urandom_range(5, 40);
            repeat (body) begin
               case ($urandom_range(19))
                  0, 1, 2, 3, 4, 5: send_command();
                  6, 7, 8, 9, 10, 11, 12, 13, 14: send_tick();
                  default: send_drive_result();
               endcase
            end
            ev = random_word();
            case ($urandom_range(3))
               0, 1: begin
                  ev.action = ACT_BEGIN_RELEASE;
                  send_event(ev);
                  ev = random_word();
                  ev.action = ACT_RELEASE_DONE;
                  send_event(ev);
               end
               2: begin
                  ev.action = ACT_FORCE_RELEASE;
                  send_event(ev);
               end
               default: ;
            endcase
         end
      end
   endtask

   task automatic run_directed();
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      send_event(event_of(ACT_BEGIN_ACQUIRE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      send_event(event_of(ACT_ACQUIRE_DONE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1, 32'h0));
      // held with no command yet, then the stop is not repeated
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd5, 1'b0, 32'h0));
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd6, 1'b0, 32'h0));
      send_event(event_of(ACT_COMMAND, 16'h7fff, 16'h8000, 16'hffff, 32'd100, 1'b0, 32'h0));
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd600, 1'b0, 32'h0));
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd601, 1'b0, 32'h0));
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd602, 1'b0, 32'h0));
      // time wraps between command and tick
      send_event(event_of(ACT_COMMAND, 16'h1, 16'h0, 16'h0, 32'hffff_fff0, 1'b0, 32'h0));
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd10, 1'b0, 32'h0));
      send_event(event_of(ACT_COMMAND, 16'h0, 16'h0, 16'h0, 32'd20, 1'b0, 32'h0));
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd20, 1'b0, 32'h0));
      send_event(event_of(ACT_DRIVE_RESULT, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h8000_0000));
      send_event(event_of(ACT_DRIVE_RESULT, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h7fff_ffff));
      send_event(event_of(ACT_DRIVE_RESULT, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      repeat (3)
         send_event(event_of(ACT_DRIVE_RESULT, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'hffff_ffff));
      send_event(event_of(ACT_COMMAND, 16'h8000, 16'h8000, 16'h8000, 32'd30, 1'b0, 32'h0));
      send_event(event_of(ACT_COMMAND, 16'h0, 16'h0, 16'h0, 32'd31, 1'b0, 32'h0));
      send_event(event_of(ACT_BEGIN_ACQUIRE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      send_event(event_of(ACT_COMMAND, 16'h0, 16'h0, 16'h0001, 32'd32, 1'b0, 32'h0));
      send_event(event_of(ACT_ACQUIRE_DONE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      // events arriving in the wrong mode still set it
      send_event(event_of(ACT_BEGIN_RELEASE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      send_event(event_of(ACT_ACQUIRE_DONE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1, 32'h0));
      send_event(event_of(ACT_TICK, 16'h0, 16'h0, 16'h0, 32'd40, 1'b0, 32'h0));
      send_event(event_of(ACT_FORCE_RELEASE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      send_event(event_of(ACT_RELEASE_DONE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      send_event(event_of(ACT_DRIVE_RESULT, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h1));
   endtask

   initial begin
      #20_000_000;
      $display("[velocity_command_authority_gate_core] ERROR");
      $finish;
   end

   initial begin
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      run_directed();

      write_reg(REG_COMMAND_TIMEOUT, 32'd0);
      write_reg(REG_FAILURE_LIMIT, 32'd1);
      run_batch(160);

      write_reg(REG_COMMAND_TIMEOUT, 32'hffff_ffff);
      write_reg(REG_FAILURE_LIMIT, 32'd255);
      run_batch(160);

      // limit of zero, and a stretch with no gaps on either side
      write_reg(REG_COMMAND_TIMEOUT, 32'd20);
      write_reg(REG_FAILURE_LIMIT, 32'd0);
      calm = 1'b1;
      run_batch(160);
      calm = 1'b0;

      write_reg(REG_COMMAND_TIMEOUT, $urandom_range(1, 300));
      write_reg(REG_FAILURE_LIMIT, $urandom_range(2, 254));
      run_batch(160);

      write_reg(REG_COMMAND_TIMEOUT, 32'd500);
      write_reg(REG_FAILURE_LIMIT, 32'd3);
      run_batch(160);

      // error streak up to saturation, release exactly at the limit
      write_reg(REG_FAILURE_LIMIT, 32'd255);
      send_event(event_of(ACT_BEGIN_ACQUIRE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b0, 32'h0));
      send_event(event_of(ACT_ACQUIRE_DONE, 16'h0, 16'h0, 16'h0, 32'd0, 1'b1, 32'h0));
      repeat (258) send_drive_result_error();

      write_reg(REG_COMMAND_TIMEOUT, 32'd40);
      write_reg(REG_FAILURE_LIMIT, 32'd2);
      run_batch(100);

      drain();
      repeat (8) @(posedge clock);
      if (board.errors == 0 && board.pending() == 0) begin
         $display("[velocity_command_authority_gate_core] OK");
      end else begin
         $display("[velocity_command_authority_gate_core] ERROR");
      end
      $finish;
   end

endmodule

// ----- velocity_command_authority_gate_core.f -----
hw/rtl/vcag_pkg.sv
hw/rtl/vcag_in_reg.sv
hw/rtl/vcag_update.sv
hw/rtl/velocity_command_authority_gate_core.sv
tb/sv/velocity_command_authority_gate_core_tb.sv
